FILE: rtl/fira_pkg.sv
package fira_pkg;

  localparam int MAX_UNITS_DEF = 256;
  localparam int RING_LIMIT    = 256;

  localparam int CNT_W      = 9;
  localparam int SIZE_W     = 17;
  localparam int IDX_W      = 8;
  localparam int OFS_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CNT_W-1:0]  UNIT_COUNT_RST = 9'd256;
  localparam logic [SIZE_W-1:0] UNIT_SIZE_RST  = 17'd64;
  localparam logic [SIZE_W-1:0] UNIT_SIZE_MAX  = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_UNIT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_SIZE  = 2'd1;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_LOOKUP  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_RANGE    = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOT_USED = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] unit_index;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] granted_index;
    logic [OFS_W-1:0] byte_offset;
    logic [CNT_W-1:0] used_count;
  } rsp_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] raw,
                                                 input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] n;
    n = raw;
    if (raw == '0) begin
      n = CNT_W'(1);
    end else if (raw > lim) begin
      n = lim;
    end
    return n;
  endfunction

endpackage

FILE: rtl/fira_ring.sv
module fira_ring
  import fira_pkg::*;
#(
  parameter int DEPTH = RING_LIMIT,
  parameter int AW    = $clog2(RING_LIMIT)
) (
  input  logic          clk,
  input  logic          clear,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [AW-1:0] rd_data
);

  logic [AW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [AW-1:0]    mem_q;
  logic [AW-1:0]    alt_q;
  logic             use_mem_q;
  logic             hit;

  assign hit = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // an entry never written holds its own number
  always_ff @(posedge clk) begin
    if (clear) begin
      use_mem_q <= 1'b0;
      alt_q     <= rd_addr;
    end else begin
      use_mem_q <= !hit && valid[rd_addr];
      alt_q     <= hit ? wr_data : rd_addr;
    end
  end

  assign rd_data = use_mem_q ? mem_q : alt_q;

endmodule

FILE: rtl/free_index_ring_allocator.sv
// The response item is registered: it is presented in the cycle after its request item is accepted.
// Throughput: one item per cycle while rsp_ready is high; the free ring read for
// the next allocate is issued in the cycle an item is taken, so back-to-back
// commands do not stall. Reset (synchronous, rst high): unit_count 256, unit_size 64,
// ring entry i holds i, all units free; a unit_count write reinitialises the pool likewise.
module free_index_ring_allocator
  import fira_pkg::*;
#(
  parameter int MAX_UNITS = MAX_UNITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = (MAX_UNITS < RING_LIMIT) ? MAX_UNITS : RING_LIMIT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(DEPTH);

  logic [CNT_W-1:0]  unit_count, unit_count_next;
  logic [SIZE_W-1:0] unit_size, unit_size_next;
  logic [AW-1:0]     head_pos, head_pos_next;
  logic [AW-1:0]     tail_pos, tail_pos_next;
  logic [AW:0]       units_used, units_used_next;
  logic [DEPTH-1:0]  in_use_marks;

  logic              accept, cfg_write, reinit, do_item;
  logic [AW:0]       n_cur, n_new;
  logic [AW:0]       head_inc, tail_inc, rd_inc;
  logic [AW-1:0]     head_wrap, tail_wrap, rd_addr, ring_rd;
  logic              idx_ok;
  logic [AW-1:0]     idx_a;
  logic              ring_we, mark_set, mark_clr;
  status_t           status;
  logic [IDX_W-1:0]  granted;
  logic [SIZE_W-1:0] size_eff;
  logic [OFS_W-1:0]  product;
  rsp_t              result;

  assign accept    = req_valid && req_ready;
  assign req_ready = !rsp_valid || rsp_ready;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign reinit    = rst || (cfg_write && (cfg_index == REG_UNIT_COUNT));
  assign do_item   = accept && !reinit;

  assign n_cur     = (AW + 1)'(eff_count(unit_count, LIMIT));
  assign head_inc  = {1'b0, head_pos} + 1'b1;
  assign head_wrap = (head_inc == n_cur) ? '0 : head_inc[AW-1:0];
  assign tail_inc  = {1'b0, tail_pos} + 1'b1;
  assign tail_wrap = (tail_inc == n_cur) ? '0 : tail_inc[AW-1:0];
  assign idx_ok    = {1'b0, req.unit_index} < CNT_W'(n_cur);
  assign idx_a     = req.unit_index[AW-1:0];

  always_comb begin
    status          = ST_OK;
    granted         = '0;
    head_pos_next   = head_pos;
    tail_pos_next   = tail_pos;
    units_used_next = units_used;
    unit_count_next = unit_count;
    unit_size_next  = unit_size;
    ring_we         = 1'b0;
    mark_set        = 1'b0;
    mark_clr        = 1'b0;

    unique case (req.cmd)
      CMD_ALLOC: begin
        if (units_used >= n_cur) begin
          status = ST_FULL;
        end else begin
          granted         = IDX_W'(ring_rd);
          head_pos_next   = head_wrap;
          units_used_next = units_used + 1'b1;
          mark_set        = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (!idx_ok) begin
          status = ST_RANGE;
        end else if (units_used == '0) begin
          status = ST_EMPTY;
        end else begin
          granted         = req.unit_index;
          tail_pos_next   = tail_wrap;
          units_used_next = units_used - 1'b1;
          ring_we         = 1'b1;
          mark_clr        = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (!idx_ok) begin
          status = ST_RANGE;
        end else if (!in_use_marks[idx_a]) begin
          status = ST_NOT_USED;
        end else begin
          granted = req.unit_index;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase

    if (!do_item) begin
      head_pos_next   = head_pos;
      tail_pos_next   = tail_pos;
      units_used_next = units_used;
      ring_we         = 1'b0;
      mark_set        = 1'b0;
      mark_clr        = 1'b0;
    end

    if (rst) begin
      unit_count_next = UNIT_COUNT_RST;
      unit_size_next  = UNIT_SIZE_RST;
    end else if (cfg_write) begin
      if (cfg_index == REG_UNIT_COUNT) begin
        unit_count_next = cfg_data[CNT_W-1:0];
      end else if (cfg_index == REG_UNIT_SIZE) begin
        unit_size_next = cfg_data[SIZE_W-1:0];
      end
    end

    if (reinit) begin
      head_pos_next   = '0;
      tail_pos_next   = '0;
      units_used_next = '0;
    end
  end

  // fetch the ring entry the next allocate will take
  assign n_new   = (AW + 1)'(eff_count(unit_count_next, LIMIT));
  assign rd_inc  = {1'b0, head_pos_next} + 1'b1;
  assign rd_addr = (rd_inc == n_new) ? '0 : rd_inc[AW-1:0];

  fira_ring #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .clear   (reinit),
    .wr_en   (ring_we),
    .wr_addr (tail_wrap),
    .wr_data (idx_a),
    .rd_addr (rd_addr),
    .rd_data (ring_rd)
  );

  assign size_eff = (unit_size > UNIT_SIZE_MAX) ? UNIT_SIZE_MAX : unit_size;
  assign product  = OFS_W'(granted) * OFS_W'(size_eff);

  always_comb begin
    result.status        = status;
    result.granted_index = (status == ST_OK) ? granted : '0;
    result.byte_offset   = (status == ST_OK) ? product : '0;
    result.used_count    = CNT_W'(units_used_next);
  end

  always_ff @(posedge clk) begin
    unit_count <= unit_count_next;
    unit_size  <= unit_size_next;
    head_pos   <= head_pos_next;
    tail_pos   <= tail_pos_next;
    units_used <= units_used_next;
  end

  always_ff @(posedge clk) begin
    if (reinit) begin
      in_use_marks <= '0;
    end else if (mark_set) begin
      in_use_marks[ring_rd] <= 1'b1;
    end else if (mark_clr) begin
      in_use_marks[idx_a] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // hold the response item until taken
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= result;
    end
  end

endmodule
